[src/sorted_priority_queue_unit_assert.svh]
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT_HOLD(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT_HOLD(lbl, expr, msg)
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared codes, widths and types for the queue cells and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_DEPTH = 16;
  localparam int PRI_W     = 8;
  localparam int TAG_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } spq_entry_t;

  typedef struct packed {
    logic       ins;
    logic       pop;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

[src/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; shifts right on insert behind a larger neighbor, takes the
// new entry at its sorted place, shifts left on pop.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_cmd_t   cmd,
  input  logic       occupied,
  input  logic       at_tail,
  input  logic       left_gt,
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output logic       gt,
  output spq_entry_t entry
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  assign gt    = occupied && (entry_r.pri > cmd.entry.pri);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt || at_tail) begin
        entry_nxt = cmd.entry;
      end
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[src/sorted_priority_queue_unit.sv]
// An accepted transaction's result is registered and shown in the next cycle.
// Throughput: one transaction per cycle; every cell updates in the same cycle.
// A result held in the output register stalls input only while out_ready is low.
// Reset: synchronous, active low; clears the entry count and output valid.
// Cell contents are not reset and are read only below the entry count.
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Row of compare-and-shift cells kept in ascending priority order, with a
// registered result per transaction.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [PRI_W-1:0]    in_priority_req,
  input  logic [TAG_W-1:0]    in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [PRI_W-1:0]    out_priority,
  output logic [TAG_W-1:0]    out_payload,
  output logic [OCC_W-1:0]    out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  spq_entry_t          res_r;
  spq_entry_t          res_nxt;
  logic [OCC_W-1:0]    occ_r;

  logic       accept;
  logic       full;
  logic       empty;
  spq_cmd_t   cmd;
  logic       gt [DEPTH];
  spq_entry_t entries [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  assign cmd.ins       = accept && (in_kind == KIND_INSERT) && !full;
  assign cmd.pop       = accept && (in_kind == KIND_POP) && !empty;
  assign cmd.entry.pri = in_priority_req;
  assign cmd.entry.tag = in_payload;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CNT_W'(i) < count_r),
      .at_tail     (CNT_W'(i) == count_r),
      .left_gt     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .left_entry  (entries[(i == 0) ? 0 : i - 1]),
      .right_entry (entries[(i == DEPTH - 1) ? i : i + 1]),
      .gt          (gt[i]),
      .entry       (entries[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_INSERTED;
    res_nxt    = '0;
    if (in_kind == KIND_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_POPPED;
        res_nxt    = entries[0];
        count_nxt  = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_priority  = res_r.pri;
  assign out_payload   = res_r.tag;
  assign out_occupancy = occ_r;

  `SPQ_ASSERT_HOLD(a_count_bound, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `SPQ_ASSERT_NEXT(a_ins_count, rst_n && cmd.ins, count_r == $past(count_r) + 1'b1, "insert did not grow count")
  `SPQ_ASSERT_NEXT(a_pop_count, rst_n && cmd.pop, count_r == $past(count_r) - 1'b1, "pop did not shrink count")
  `SPQ_ASSERT_IMPL(a_zero_res, out_valid_r && (status_r != ST_POPPED), res_r == '0, "nonzero entry on non-pop result")

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives insert and pop transactions through the valid/ready input channel
// with bursty traffic, stalls the result channel on its own pattern, and
// checks every result against the directed table or a sorted-list model.
// The table covers empty pops, a full queue, priority extremes and ties;
// random phases then push the queue between empty and full.
// ----------------------------------------------------------------------------
module tb_top;
  import spq_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PRI_W-1:0]    pri;
    logic [TAG_W-1:0]    tag;
    logic [OCC_W-1:0]    occ;
  } queue_result_t;

  typedef struct packed {
    logic          kind;
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
    logic          typed;
    queue_result_t res;
  } directed_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 400;

  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{KIND_POP,    8'h00, 16'h0000, 1'b1, '{ST_EMPTY,    8'h00, 16'h0000, 5'd0}},
    '{KIND_INSERT, 8'hff, 16'hffff, 1'b1, '{ST_INSERTED, 8'h00, 16'h0000, 5'd1}},
    '{KIND_POP,    8'h00, 16'h0000, 1'b1, '{ST_POPPED,   8'hff, 16'hffff, 5'd0}},
    '{KIND_POP,    8'h00, 16'h0000, 1'b1, '{ST_EMPTY,    8'h00, 16'h0000, 5'd0}},
    '{KIND_INSERT, 8'h00, 16'h0000, 1'b1, '{ST_INSERTED, 8'h00, 16'h0000, 5'd1}},
    '{KIND_INSERT, 8'h80, 16'h1111, 1'b0, '0},
    '{KIND_INSERT, 8'h80, 16'h2222, 1'b0, '0},
    '{KIND_INSERT, 8'h7f, 16'haaaa, 1'b0, '0},
    '{KIND_INSERT, 8'hff, 16'h5555, 1'b0, '0},
    '{KIND_INSERT, 8'h80, 16'h3333, 1'b0, '0},
    '{KIND_INSERT, 8'h01, 16'h0001, 1'b0, '0},
    '{KIND_INSERT, 8'hfe, 16'hfffe, 1'b0, '0},
    '{KIND_INSERT, 8'h80, 16'h4444, 1'b0, '0},
    '{KIND_INSERT, 8'h40, 16'h8000, 1'b0, '0},
    '{KIND_INSERT, 8'hc0, 16'h7fff, 1'b0, '0},
    '{KIND_INSERT, 8'h00, 16'hffff, 1'b0, '0},
    '{KIND_INSERT, 8'hff, 16'h0000, 1'b0, '0},
    '{KIND_INSERT, 8'h20, 16'hc3c3, 1'b0, '0},
    '{KIND_INSERT, 8'ha5, 16'h5a5a, 1'b0, '0},
    '{KIND_INSERT, 8'h5a, 16'ha5a5, 1'b0, '0},
    '{KIND_INSERT, 8'h10, 16'hbeef, 1'b1, '{ST_FULL,     8'h00, 16'h0000, 5'd16}},
    '{KIND_POP,    8'hff, 16'hffff, 1'b0, '0},
    '{KIND_POP,    8'h00, 16'h0000, 1'b0, '0},
    '{KIND_POP,    8'h00, 16'h0000, 1'b0, '0},
    '{KIND_INSERT, 8'h55, 16'h1234, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_kind = KIND_INSERT;
  logic [PRI_W-1:0]    in_priority_req = '0;
  logic [TAG_W-1:0]    in_payload = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [PRI_W-1:0]    out_priority;
  logic [TAG_W-1:0]    out_payload;
  logic [OCC_W-1:0]    out_occupancy;

  spq_entry_t    model_entries [SPQ_DEPTH];
  int            model_count = 0;
  queue_result_t pending_results [$];
  int            mismatch_count = 0;
  int            burst_left = 0;
  logic [7:0]    ready_phase = '0;

  sorted_priority_queue_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_priority_req(in_priority_req),
    .in_payload   (in_payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .out_occupancy(out_occupancy)
  );

  always #5 clk = ~clk;

  function automatic queue_result_t apply_queue_op(logic kind, logic [PRI_W-1:0] pri,
                                                   logic [TAG_W-1:0] tag);
    queue_result_t r;
    int slot;
    int i;
    r = '0;
    if (kind == KIND_INSERT) begin
      if (model_count >= SPQ_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < model_count && model_entries[slot].pri <= pri) slot++;
        for (i = model_count; i > slot; i--) model_entries[i] = model_entries[i-1];
        model_entries[slot].pri = pri;
        model_entries[slot].tag = tag;
        model_count++;
        r.status = ST_INSERTED;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_POPPED;
      r.pri    = model_entries[0].pri;
      r.tag    = model_entries[0].tag;
      for (i = 1; i < model_count; i++) model_entries[i-1] = model_entries[i];
      model_count--;
    end
    r.occ = model_count[OCC_W-1:0];
    return r;
  endfunction

  task automatic send_transaction(logic kind, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tag,
                                  logic typed, queue_result_t typed_res);
    queue_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_priority_req <= pri;
    in_payload      <= tag;
    do @(posedge clk); while (!in_ready);
    predicted = apply_queue_op(kind, pri, tag);
    pending_results.push_back(typed ? typed_res : predicted);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: cycle through always-ready, coin-flip, slow and mostly-ready stretches
  always @(posedge clk) begin
    ready_phase <= ready_phase + 8'd1;
    case (ready_phase[7:6])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (ready_phase[1:0] == 2'd3);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    queue_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_status);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_status);
          mismatch_count++;
        end
        if (out_priority !== exp_res.pri) begin
          $error("out_priority: expected %0h, actual %0h", exp_res.pri, out_priority);
          mismatch_count++;
        end
        if (out_payload !== exp_res.tag) begin
          $error("out_payload: expected %0h, actual %0h", exp_res.tag, out_payload);
          mismatch_count++;
        end
        if (out_occupancy !== exp_res.occ) begin
          $error("occupancy: expected %0d, actual %0d", exp_res.occ, out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int mode;
    int seg_left;
    logic kind;
    logic [PRI_W-1:0] pri;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < NUM_DIRECTED; n++) begin
      send_transaction(DIRECTED_ROWS[n].kind, DIRECTED_ROWS[n].pri, DIRECTED_ROWS[n].tag,
                       DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].res);
    end
    wait_drained();

    seg_left = 0;
    mode     = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      case (mode)
        0: kind = ($urandom_range(0, 4) == 0) ? KIND_POP : KIND_INSERT;
        1: kind = ($urandom_range(0, 4) == 0) ? KIND_INSERT : KIND_POP;
        default: kind = $urandom_range(0, 1) ? KIND_POP : KIND_INSERT;
      endcase
      case ($urandom_range(0, 3))
        0: pri = PRI_W'($urandom_range(0, 3));
        1: pri = PRI_W'($urandom_range(252, 255));
        default: pri = PRI_W'($urandom_range(0, 255));
      endcase
      send_transaction(kind, pri, TAG_W'($urandom_range(0, 65535)), 1'b0, '0);
      if (n == NUM_RANDOM / 2) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
